// ===== design/lz77_token_packer_assert.svh =====
// assertion macros shared by the lz77 token packer rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef LZ77_TOKEN_PACKER_ASSERT_SVH
`define LZ77_TOKEN_PACKER_ASSERT_SVH

// same-cycle implication, off during reset
`define LTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lz77_token_packer: same-cycle check failed");

// next-cycle implication, off during reset
`define LTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lz77_token_packer: next-cycle check failed");

`endif

// ===== design/ltp_pkg.sv =====
// shared types and constants of the lz77 token packer
// no dependencies; used by front, queue, back and the top level
package ltp_pkg;

	localparam int OUT_BYTES    = 65536;
	localparam int WINDOW_BYTES = 8192;
	localparam int DESC_DEPTH   = 4;

	// effective buffer size never exceeds the 17-bit register range
	localparam logic [16:0] CAP_LIMIT = 17'((OUT_BYTES < 131071) ? OUT_BYTES : 131071);
	localparam logic [16:0] CAP_RESET = 17'((OUT_BYTES < 65536) ? OUT_BYTES : 65536);
	localparam logic [16:0] WP_RESET  = 17'd4;

	typedef enum logic [1:0] {
		MODE_LIT    = 2'd0,
		MODE_MATCH  = 2'd1,
		MODE_FINISH = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	// byte groups of one item, in emission order
	localparam int NUM_GRP = 6;
	typedef logic [2:0] grp_t;
	localparam grp_t GRP_MAIN  = 3'd0;
	localparam grp_t GRP_NIB   = 3'd1;
	localparam grp_t GRP_EXT   = 3'd2;
	localparam grp_t GRP_LEN16 = 3'd3;
	localparam grp_t GRP_LEN32 = 3'd4;
	localparam grp_t GRP_FLAG  = 3'd5;

	typedef struct packed {
		logic [NUM_GRP-1:0] grp_en;
		logic               tail_en;
		logic               tail_status;
		logic               done;
		logic [16:0]        total;
		logic               main_two;
		logic [15:0]        main_addr;
		logic [15:0]        main_val;
		logic [15:0]        nib_addr;
		logic [7:0]         nib_val;
		logic [15:0]        ext_addr;
		logic [7:0]         ext_val;
		logic [15:0]        len_addr;
		logic               len_long;
		logic [31:0]        len_val;
		logic [15:0]        flag_addr;
		logic [31:0]        flag_val;
	} desc_t;

endpackage

// ===== design/ltp_front.sv =====
// front end: takes a token, checks buffer space, keeps stream state and
// builds one write descriptor per token; depends on ltp_pkg
module ltp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [16:0]         cfg_data,
	input  logic                in_acc,
	input  logic [1:0]          mode,
	input  logic [7:0]          literal_byte,
	input  logic [13:0]         match_offset,
	input  logic [31:0]         match_length,
	output logic                desc_push,
	output ltp_pkg::desc_t      desc
);

	logic [16:0] cap_q;
	logic [16:0] wp_q;
	logic [31:0] fpad_q;
	logic [4:0]  cnt_q;
	logic [15:0] flag_slot_q;
	logic        nib_pend_q;
	logic [15:0] nib_addr_q;
	logic [3:0]  nib_low_q;
	logic        err_q;

	ltp_pkg::mode_t md;
	logic        is_lit, is_match, is_fin;
	logic [13:0] off_c;
	logic [12:0] off_m1;
	logic [31:0] len0;
	logic [2:0]  code_len;
	logic        need_nib, need_ext, need_len, len_long, new_nib;
	logic [3:0]  nib_n;
	logic [7:0]  ext_val;
	logic [3:0]  main_n, off2, off3, off4, lbytes;
	logic        ok0, nib_ok, ext_ok, len_ok, fl_ok, slot_ok, full_tok;
	logic        e0, e1, e2, e3, e4, e5, pass1, pass2, pass3, tok_ok, fin_ok;
	logic [31:0] fpad_new;

	function automatic logic room(input logic [16:0] addr, input logic [3:0] n,
			input logic [16:0] cap);
		room = ({1'b0, addr} + {14'b0, n}) <= {1'b0, cap};
	endfunction

	always_comb begin
		md       = ltp_pkg::mode_t'(mode);
		is_lit   = (md == ltp_pkg::MODE_LIT);
		is_match = (md == ltp_pkg::MODE_MATCH);
		is_fin   = (md == ltp_pkg::MODE_FINISH);

		if (match_offset == 14'd0)
			off_c = 14'd1;
		else if (match_offset > 14'(ltp_pkg::WINDOW_BYTES))
			off_c = 14'(ltp_pkg::WINDOW_BYTES);
		else
			off_c = match_offset;
		off_m1 = 13'(off_c - 14'd1);

		len0     = (match_length < 32'd3) ? 32'd0 : match_length - 32'd3;
		code_len = (len0 < 32'd7) ? len0[2:0] : 3'd7;
		need_nib = is_match && (len0 >= 32'd7);
		need_ext = is_match && (len0 >= 32'd22);
		need_len = is_match && (len0 >= 32'd277);
		len_long = len0 > 32'h0000_FFFF;
		new_nib  = need_nib && !nib_pend_q;
		nib_n    = need_ext ? 4'hF : 4'(len0[4:0] - 5'd7);
		ext_val  = need_len ? 8'hFF : 8'(len0[8:0] - 9'd22);

		// running byte offsets from the write pointer after each group
		main_n = is_lit ? 4'd1 : 4'd2;
		off2   = main_n + {3'b0, new_nib};
		off3   = off2 + {3'b0, need_ext};
		lbytes = need_len ? (len_long ? 4'd6 : 4'd2) : 4'd0;
		off4   = off3 + lbytes;

		full_tok = (cnt_q == 5'd31);
		ok0      = room(wp_q, main_n, cap_q);
		nib_ok   = nib_pend_q ? room({1'b0, nib_addr_q}, 4'd1, cap_q) : room(wp_q, off2, cap_q);
		ext_ok   = room(wp_q, off3, cap_q);
		len_ok   = room(wp_q, off4, cap_q);
		fl_ok    = room({1'b0, flag_slot_q}, 4'd4, cap_q);
		slot_ok  = room(wp_q, 4'(off4 + 4'd4), cap_q);

		// a failing group stops everything after it
		e0    = ok0;
		e1    = e0 && need_nib && nib_ok;
		pass1 = e0 && (!need_nib || nib_ok);
		e2    = pass1 && need_ext && ext_ok;
		pass2 = pass1 && (!need_ext || ext_ok);
		e3    = pass2 && need_len && len_ok;
		e4    = e3 && len_long;
		pass3 = pass2 && (!need_len || len_ok);
		e5    = pass3 && full_tok && fl_ok;
		tok_ok = pass3 && (!full_tok || (fl_ok && slot_ok));
		fin_ok = !err_q && fl_ok;

		// flag word kept padded with ones below the next free bit
		fpad_new = fpad_q;
		fpad_new[5'd31 - cnt_q] = is_match;

		desc.main_two  = is_match;
		desc.main_addr = wp_q[15:0];
		desc.main_val  = is_lit ? {8'h00, literal_byte} : {off_m1, code_len};
		desc.nib_addr  = nib_pend_q ? nib_addr_q : 16'(wp_q + 17'd2);
		desc.nib_val   = nib_pend_q ? {nib_n, nib_low_q} : {4'h0, nib_n};
		desc.ext_addr  = 16'(wp_q + 17'(off2));
		desc.ext_val   = ext_val;
		desc.len_addr  = 16'(wp_q + 17'(off3));
		desc.len_long  = len_long;
		desc.len_val   = len0;
		desc.flag_addr = flag_slot_q;
		desc.flag_val  = is_fin ? fpad_q : fpad_new;
		desc.done      = is_fin;
		desc.total     = fin_ok ? wp_q : 17'd0;

		case (md)
			ltp_pkg::MODE_LIT, ltp_pkg::MODE_MATCH: begin
				desc.grp_en      = err_q ? '0 : {e5, e4, e3, e2, e1, e0};
				desc.tail_en     = err_q || !tok_ok;
				desc.tail_status = 1'b1;
			end
			ltp_pkg::MODE_FINISH: begin
				desc.grp_en      = {fin_ok, 5'b0};
				desc.tail_en     = !fin_ok;
				desc.tail_status = 1'b1;
			end
			default: begin
				desc.grp_en      = '0;
				desc.tail_en     = 1'b1;
				desc.tail_status = err_q;
			end
		endcase
	end

	assign desc_push = in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ltp_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= (cfg_data > ltp_pkg::CAP_LIMIT) ? ltp_pkg::CAP_LIMIT : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= ltp_pkg::WP_RESET;
			fpad_q      <= '1;
			cnt_q       <= '0;
			flag_slot_q <= '0;
			nib_pend_q  <= 1'b0;
			nib_addr_q  <= '0;
			nib_low_q   <= '0;
			err_q       <= 1'b0;
		end else if (in_acc) begin
			case (md)
				ltp_pkg::MODE_LIT, ltp_pkg::MODE_MATCH: begin
					if (!err_q) begin
						if (!tok_ok) begin
							err_q <= 1'b1;
						end else begin
							wp_q   <= wp_q + 17'(off4) + (full_tok ? 17'd4 : 17'd0);
							cnt_q  <= cnt_q + 5'd1;
							fpad_q <= full_tok ? '1 : fpad_new;
							if (full_tok)
								flag_slot_q <= 16'(wp_q + 17'(off4));
							if (need_nib)
								nib_pend_q <= !nib_pend_q;
							if (new_nib) begin
								nib_addr_q <= 16'(wp_q + 17'd2);
								nib_low_q  <= nib_n;
							end
						end
					end
				end
				ltp_pkg::MODE_FINISH: begin
					wp_q        <= ltp_pkg::WP_RESET;
					fpad_q      <= '1;
					cnt_q       <= '0;
					flag_slot_q <= '0;
					nib_pend_q  <= 1'b0;
					nib_addr_q  <= '0;
					nib_low_q   <= '0;
					err_q       <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/ltp_queue.sv =====
// descriptor queue between front and back
// depends on ltp_pkg for the descriptor type
module ltp_queue #(
	parameter int DEPTH = ltp_pkg::DESC_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ltp_pkg::desc_t din,
	output logic           full,
	input  logic           pop,
	output ltp_pkg::desc_t dout,
	output logic           valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ltp_pkg::desc_t slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== design/ltp_back.sv =====
// back end: walks the head descriptor's byte groups, one result per cycle
// unless pop stalls, into the output register; depends on ltp_pkg and the assert macros
`include "lz77_token_packer_assert.svh"

module ltp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ltp_pkg::desc_t head,
	input  logic           head_valid,
	output logic           head_pop,
	output logic           empty,
	input  logic           pop,
	output logic [15:0]    byte_address,
	output logic [7:0]     byte_value,
	output logic           write_valid,
	output logic           stream_done,
	output logic [16:0]    total_bytes,
	output logic           status,
	output logic           last
);

	logic                        act_q;
	logic [ltp_pkg::NUM_GRP-1:0] rem_q;
	logic                        tail_q;
	logic [1:0]                  bcnt_q;
	logic                        ov_q;

	logic [ltp_pkg::NUM_GRP-1:0] m, m_next;
	logic                        t, adv, has_wr, grp_last, item_last;
	ltp_pkg::grp_t               g;
	logic [1:0]                  last_idx;
	logic [15:0]                 base, a_off;
	logic [7:0]                  val;

	always_comb begin
		m = act_q ? rem_q : head.grp_en;
		t = act_q ? tail_q : head.tail_en;
		g = ltp_pkg::GRP_MAIN;
		for (int i = ltp_pkg::NUM_GRP - 1; i >= 0; i--) begin
			if (m[i])
				g = ltp_pkg::grp_t'(i);
		end

		a_off = {14'b0, bcnt_q};
		case (g)
			ltp_pkg::GRP_MAIN: begin
				last_idx = head.main_two ? 2'd1 : 2'd0;
				base     = head.main_addr;
				val      = bcnt_q[0] ? head.main_val[15:8] : head.main_val[7:0];
			end
			ltp_pkg::GRP_NIB: begin
				last_idx = 2'd0;
				base     = head.nib_addr;
				val      = head.nib_val;
			end
			ltp_pkg::GRP_EXT: begin
				last_idx = 2'd0;
				base     = head.ext_addr;
				val      = head.ext_val;
			end
			ltp_pkg::GRP_LEN16: begin
				// a long length starts with a zero half-word
				last_idx = 2'd1;
				base     = head.len_addr;
				val      = head.len_long ? 8'h00 : head.len_val[8*bcnt_q[0] +: 8];
			end
			ltp_pkg::GRP_LEN32: begin
				last_idx = 2'd3;
				base     = head.len_addr;
				a_off    = {14'b0, bcnt_q} + 16'd2;
				val      = head.len_val[8*bcnt_q +: 8];
			end
			ltp_pkg::GRP_FLAG: begin
				last_idx = 2'd3;
				base     = head.flag_addr;
				val      = head.flag_val[8*bcnt_q +: 8];
			end
			default: begin
				last_idx = 2'd0;
				base     = '0;
				val      = '0;
			end
		endcase

		has_wr    = (m != '0);
		grp_last  = (bcnt_q == last_idx);
		m_next    = grp_last ? (m & ~(ltp_pkg::NUM_GRP'(1) << g)) : m;
		item_last = has_wr ? (grp_last && (m_next == '0) && !t) : 1'b1;
		adv       = head_valid && (!ov_q || pop);
	end

	assign head_pop = adv && item_last;
	assign empty    = !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			rem_q  <= '0;
			tail_q <= 1'b0;
			bcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (adv)
				ov_q <= 1'b1;
			else if (pop)
				ov_q <= 1'b0;
			if (adv) begin
				if (item_last) begin
					act_q  <= 1'b0;
					bcnt_q <= '0;
				end else begin
					act_q  <= 1'b1;
					rem_q  <= m_next;
					tail_q <= t;
					bcnt_q <= grp_last ? 2'd0 : bcnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_address <= has_wr ? base + a_off : 16'd0;
			byte_value   <= has_wr ? val : 8'd0;
			write_valid  <= has_wr;
			stream_done  <= item_last && head.done;
			total_bytes  <= (item_last && head.done) ? head.total : 17'd0;
			status       <= has_wr ? 1'b0 : head.tail_status;
			last         <= item_last;
		end
	end

	`LTP_ASSERT_IMP(a_act_has_head, clk, arst_n, act_q, head_valid)
	`LTP_ASSERT_IMP(a_act_has_work, clk, arst_n, act_q, (rem_q != '0) || tail_q)
	`LTP_ASSERT_IMP(a_idle_bcnt_zero, clk, arst_n, !act_q, bcnt_q == 2'd0)
	`LTP_ASSERT_NXT(a_mid_item_stays, clk, arst_n, adv && !item_last, act_q)

endmodule

// ===== design/lz77_token_packer.sv =====
// top level of the lz77 token packer: front, descriptor queue and back
// depends on ltp_pkg, ltp_front, ltp_queue and ltp_back
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  token   | push / full         | mode, literal_byte, match_offset, match_length
//  result  | empty / pop         | byte_address, byte_value, write_valid,
//          |                     | stream_done, total_bytes, status, last
//  config  | cfg_valid/cfg_ready | cfg_data (out_capacity)
//
// a token gives 1 to 15 results (2 for a short match that neither fills
// a flag word nor meets a buffer error).
// the front takes one token per cycle while the descriptor queue has room.
// control state is cleared by arst_n; queue slots and result data are not reset
// and need no clearing pass.
// a low pop stalls the back only; the front keeps filling the queue until full.
module lz77_token_packer #(
	parameter int DESC_DEPTH = ltp_pkg::DESC_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  literal_byte,
	input  logic [13:0] match_offset,
	input  logic [31:0] match_length,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] byte_address,
	output logic [7:0]  byte_value,
	output logic        write_valid,
	output logic        stream_done,
	output logic [16:0] total_bytes,
	output logic        status,
	output logic        last
);

	ltp_pkg::desc_t fe_desc, q_head;
	logic           fe_push, q_full, q_valid, be_pop, in_acc;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign in_acc    = push && !q_full;

	ltp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_acc       (in_acc),
		.mode         (mode),
		.literal_byte (literal_byte),
		.match_offset (match_offset),
		.match_length (match_length),
		.desc_push    (fe_push),
		.desc         (fe_desc)
	);

	ltp_queue #(
		.DEPTH (DESC_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.din    (fe_desc),
		.full   (q_full),
		.pop    (be_pop),
		.dout   (q_head),
		.valid  (q_valid)
	);

	ltp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_valid   (q_valid),
		.head_pop     (be_pop),
		.empty        (empty),
		.pop          (pop),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.write_valid  (write_valid),
		.stream_done  (stream_done),
		.total_bytes  (total_bytes),
		.status       (status),
		.last         (last)
	);

endmodule

// ===== tb/lz77_token_packer_check.sv =====
// scoreboard for the lz77 token packer: watches the token, result and config channels
// keeps its own copy of the packer state, predicts every byte write and compares
// depends on ltp_pkg for the mode codes and size constants
module lz77_token_packer_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [16:0] cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  literal_byte,
	input  logic [13:0] match_offset,
	input  logic [31:0] match_length,
	input  logic        empty,
	input  logic        pop,
	input  logic [15:0] byte_address,
	input  logic [7:0]  byte_value,
	input  logic        write_valid,
	input  logic        stream_done,
	input  logic [16:0] total_bytes,
	input  logic        status,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  value;
		logic        wr;
		logic        done;
		logic [16:0] total;
		logic        status;
		logic        last;
	} byte_result_t;

	byte_result_t packed_q[$];

	logic [16:0] capacity;
	int unsigned wr_ptr;
	int unsigned flag_slot;
	int unsigned flag_cnt;
	logic [31:0] flag_bits;
	logic        nib_pending;
	int unsigned nib_addr;
	logic [3:0]  nib_low;
	logic        err_sticky;
	int          errors = 0;
	int          results_seen = 0;

	function automatic bit fits(int unsigned addr, int unsigned n);
		int unsigned lim;
		lim = (capacity > ltp_pkg::OUT_BYTES) ? ltp_pkg::OUT_BYTES : capacity;
		return (addr + n) <= lim;
	endfunction

	function automatic void add_result(logic [15:0] a, logic [7:0] v, logic w, logic d,
			logic [16:0] t, logic s);
		packed_q.push_back('{addr: a, value: v, wr: w, done: d, total: t, status: s,
			last: 1'b0});
	endfunction

	// little-endian, one write per byte
	function automatic void emit_bytes(int unsigned addr, logic [31:0] v, int nb);
		for (int i = 0; i < nb; i++)
			add_result(16'(addr + i), 8'(v >> (8 * i)), 1'b1, 1'b0, 17'd0, 1'b0);
	endfunction

	function automatic void buffer_error();
		err_sticky = 1'b1;
		add_result(16'd0, 8'd0, 1'b0, 1'b0, 17'd0, 1'b1);
	endfunction

	function automatic void restart_stream();
		wr_ptr      = ltp_pkg::WP_RESET;
		flag_slot   = 0;
		flag_cnt    = 0;
		flag_bits   = '0;
		nib_pending = 1'b0;
		nib_addr    = 0;
		nib_low     = '0;
		err_sticky  = 1'b0;
	endfunction

	// a full flag word goes back to its slot and the next slot is reserved
	function automatic bit count_flag(logic b);
		flag_bits = {flag_bits[30:0], b};
		flag_cnt++;
		if (flag_cnt == 32) begin
			if (!fits(flag_slot, 4))
				return 1'b0;
			emit_bytes(flag_slot, flag_bits, 4);
			flag_cnt = 0;
			if (!fits(wr_ptr, 4))
				return 1'b0;
			flag_slot = wr_ptr & 32'hFFFF;
			wr_ptr += 4;
		end
		return 1'b1;
	endfunction

	function automatic void pack_token(logic [1:0] m, logic [7:0] lit, logic [13:0] off_in,
			logic [31:0] len_in);
		int unsigned off;
		int unsigned len;
		int unsigned n;
		logic [31:0] pad;
		case (m)
			ltp_pkg::MODE_RSVD: add_result(16'd0, 8'd0, 1'b0, 1'b0, 17'd0, err_sticky);
			ltp_pkg::MODE_FINISH: begin
				if (!err_sticky && fits(flag_slot, 4)) begin
					pad = '1;
					if (flag_cnt != 0)
						pad = (flag_bits << (32 - flag_cnt)) | ((32'd1 << (32 - flag_cnt)) - 1);
					emit_bytes(flag_slot, pad, 4);
					packed_q[packed_q.size() - 1].done  = 1'b1;
					packed_q[packed_q.size() - 1].total = 17'(wr_ptr);
				end else begin
					add_result(16'd0, 8'd0, 1'b0, 1'b1, 17'd0, 1'b1);
				end
				restart_stream();
			end
			default: begin
				if (err_sticky) begin
					add_result(16'd0, 8'd0, 1'b0, 1'b0, 17'd0, 1'b1);
					return;
				end
				if (m == ltp_pkg::MODE_LIT) begin
					if (!fits(wr_ptr, 1)) begin buffer_error(); return; end
					emit_bytes(wr_ptr, 32'(lit), 1);
					wr_ptr += 1;
					if (!count_flag(1'b0))
						buffer_error();
					return;
				end
				off = off_in;
				if (off < 1)
					off = 1;
				if (off > ltp_pkg::WINDOW_BYTES)
					off = ltp_pkg::WINDOW_BYTES;
				len = (len_in < 3) ? 0 : len_in - 3;
				if (!fits(wr_ptr, 2)) begin buffer_error(); return; end
				emit_bytes(wr_ptr, ((off - 1) << 3) | ((len < 7) ? len : 7), 2);
				wr_ptr += 2;
				if (len >= 7) begin
					len -= 7;
					n = (len < 15) ? len : 15;
					// two matches share one nibble byte, the second fills the high half
					if (nib_pending) begin
						if (!fits(nib_addr, 1)) begin buffer_error(); return; end
						emit_bytes(nib_addr, {24'd0, n[3:0], nib_low}, 1);
						nib_pending = 1'b0;
					end else begin
						if (!fits(wr_ptr, 1)) begin buffer_error(); return; end
						emit_bytes(wr_ptr, n, 1);
						nib_addr    = wr_ptr & 32'hFFFF;
						nib_low     = n[3:0];
						nib_pending = 1'b1;
						wr_ptr += 1;
					end
					if (len >= 15) begin
						len -= 15;
						if (!fits(wr_ptr, 1)) begin buffer_error(); return; end
						emit_bytes(wr_ptr, (len < 255) ? len : 255, 1);
						wr_ptr += 1;
						if (len >= 255) begin
							len += 22;
							if (len <= 32'hFFFF) begin
								if (!fits(wr_ptr, 2)) begin buffer_error(); return; end
								emit_bytes(wr_ptr, len, 2);
								wr_ptr += 2;
							end else begin
								if (!fits(wr_ptr, 6)) begin buffer_error(); return; end
								emit_bytes(wr_ptr, 32'd0, 2);
								emit_bytes(wr_ptr + 2, len, 4);
								wr_ptr += 6;
							end
						end
					end
				end
				if (!count_flag(1'b1))
					buffer_error();
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		byte_result_t want;
		byte_result_t got;
		if (!arst_n) begin
			capacity = ltp_pkg::CAP_RESET;
			restart_stream();
			packed_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (pop && !empty) begin
				got = {byte_address, byte_value, write_valid, stream_done, total_bytes,
					status, last};
				if (packed_q.size() == 0) begin
					if (errors < 10)
						$display("#%0d unexpected: addr %h val %h wr %b done %b total %0d st %b last %b",
							results_seen, got.addr, got.value, got.wr, got.done, got.total,
							got.status, got.last);
					errors++;
				end else begin
					want = packed_q.pop_front();
					if (got.addr !== want.addr || got.value !== want.value || got.wr !== want.wr
							|| got.done !== want.done || got.total !== want.total
							|| got.status !== want.status || got.last !== want.last) begin
						if (errors < 10) begin
							$display("#%0d expected: addr %h val %h wr %b done %b total %0d st %b last %b",
								results_seen, want.addr, want.value, want.wr, want.done,
								want.total, want.status, want.last);
							$display("#%0d actual:   addr %h val %h wr %b done %b total %0d st %b last %b",
								results_seen, got.addr, got.value, got.wr, got.done,
								got.total, got.status, got.last);
						end
						errors++;
					end
				end
				results_seen++;
			end
			if (push && !full) begin
				pack_token(mode, literal_byte, match_offset, match_length);
				packed_q[packed_q.size() - 1].last = 1'b1;
			end
			mismatches  <= errors;
			outstanding <= packed_q.size();
		end
	end

endmodule

// ===== tb/lz77_token_packer_tb.sv =====
// top of the lz77 token packer testbench: clock, reset, token and config requests
// depends on ltp_pkg, lz77_token_packer and lz77_token_packer_check
module lz77_token_packer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  mode = ltp_pkg::MODE_LIT;
	logic [7:0]  literal_byte = '0;
	logic [13:0] match_offset = '0;
	logic [31:0] match_length = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] byte_address;
	logic [7:0]  byte_value;
	logic        write_valid;
	logic        stream_done;
	logic [16:0] total_bytes;
	logic        status;
	logic        last;

	int mismatches;
	int outstanding;
	int tx_idle = 34;
	int rx_idle = 52;

	lz77_token_packer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.literal_byte(literal_byte),
		.match_offset(match_offset),
		.match_length(match_length),
		.empty       (empty),
		.pop         (pop),
		.byte_address(byte_address),
		.byte_value  (byte_value),
		.write_valid (write_valid),
		.stream_done (stream_done),
		.total_bytes (total_bytes),
		.status      (status),
		.last        (last)
	);

	lz77_token_packer_check scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.literal_byte(literal_byte),
		.match_offset(match_offset),
		.match_length(match_length),
		.empty       (empty),
		.pop         (pop),
		.byte_address(byte_address),
		.byte_value  (byte_value),
		.write_valid (write_valid),
		.stream_done (stream_done),
		.total_bytes (total_bytes),
		.status      (status),
		.last        (last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle);
	end

	// push stays high across back-to-back requests, dropped only for a gap
	task automatic send_token(input ltp_pkg::mode_t m, input logic [7:0] lit,
			input logic [13:0] off, input logic [31:0] len);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		mode         <= m;
		literal_byte <= lit;
		match_offset <= off;
		match_length <= len;
		do @(posedge clk); while (full);
	endtask

	task automatic send_random(input ltp_pkg::mode_t m);
		logic [31:0] len;
		logic [13:0] off;
		int r;
		r = $urandom_range(99);
		if (r < 40)
			len = $urandom_range(3, 9);
		else if (r < 60)
			len = $urandom_range(10, 24);
		else if (r < 75)
			len = $urandom_range(25, 279);
		else if (r < 85)
			len = $urandom_range(280, 65538);
		else if (r < 92)
			len = $urandom_range(65539, 200000);
		else if (r < 96)
			len = $urandom_range(0, 2);
		else
			len = $urandom;
		r = $urandom_range(99);
		if (r < 85)
			off = 14'($urandom_range(1, ltp_pkg::WINDOW_BYTES));
		else if (r < 95)
			off = 14'($urandom);
		else
			off = 14'd0;
		send_token(m, 8'($urandom), off, len);
	endtask

	// mostly complete streams closed by a finish, with the odd reserved or early finish
	task automatic run_streams(input int count);
		int left;
		int stream_len;
		int r;
		left = count;
		while (left > 0) begin
			stream_len = $urandom_range(1, 75);
			for (int i = 0; i < stream_len && left > 0; i++) begin
				r = $urandom_range(99);
				if (r < 45)
					send_random(ltp_pkg::MODE_LIT);
				else if (r < 95)
					send_random(ltp_pkg::MODE_MATCH);
				else if (r < 98)
					send_random(ltp_pkg::MODE_RSVD);
				else
					send_random(ltp_pkg::MODE_FINISH);
				left--;
			end
			if (left > 0) begin
				send_random(ltp_pkg::MODE_FINISH);
				left--;
			end
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_capacity(input logic [16:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("lz77_token_packer regression: fail");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		set_capacity(17'd65536);

		// literal extremes, then every length band of a match
		send_token(ltp_pkg::MODE_LIT, 8'h00, 14'd1, 32'd3);
		send_token(ltp_pkg::MODE_LIT, 8'hFF, 14'd1, 32'd3);
		send_token(ltp_pkg::MODE_MATCH, 8'h5A, 14'd1, 32'd3);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd8192, 32'd9);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd0, 32'd10);
		send_token(ltp_pkg::MODE_MATCH, 8'hFF, 14'd16383, 32'd11);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd8193, 32'd25);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd4096, 32'd279);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd2, 32'd280);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd100, 32'd65538);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd101, 32'd65539);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd8191, 32'hFFFF_FFFF);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd7, 32'd0);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd7, 32'd2);
		send_token(ltp_pkg::MODE_RSVD, 8'hFF, 14'h3FFF, 32'hFFFF_FFFF);
		send_token(ltp_pkg::MODE_FINISH, 8'h00, 14'd0, 32'd0);
		// empty stream pads a whole flag word
		send_token(ltp_pkg::MODE_FINISH, 8'h00, 14'd0, 32'd0);

		// smallest buffer for a literal: one literal fits, the match overflows and the error sticks
		drain();
		set_capacity(17'd5);
		send_token(ltp_pkg::MODE_LIT, 8'hA5, 14'd1, 32'd3);
		send_token(ltp_pkg::MODE_MATCH, 8'h00, 14'd1, 32'd3);
		send_token(ltp_pkg::MODE_RSVD, 8'h00, 14'd0, 32'd0);
		send_token(ltp_pkg::MODE_LIT, 8'h3C, 14'd0, 32'd0);
		send_token(ltp_pkg::MODE_FINISH, 8'h00, 14'd0, 32'd0);

		// no buffer at all: even the flag word of a finish does not fit
		drain();
		set_capacity(17'd0);
		send_token(ltp_pkg::MODE_FINISH, 8'h00, 14'd0, 32'd0);
		send_token(ltp_pkg::MODE_LIT, 8'h81, 14'd0, 32'd0);
		send_token(ltp_pkg::MODE_FINISH, 8'h00, 14'd0, 32'd0);

		for (int k = 0; k < 3; k++) begin
			drain();
			tx_idle = (k == 0) ? 34 : (k == 1) ? 52 : 0;
			rx_idle = (k == 0) ? 52 : (k == 1) ? 34 : 0;
			if (k == 0)
				set_capacity(17'd131071);
			else if (k == 1)
				set_capacity(17'd65536);
			else
				set_capacity(17'($urandom_range(1000, 65536)));
			run_streams(70);
			// streams may be left open here, so a smaller buffer can cut one short
			drain();
			set_capacity(17'($urandom_range(5, 300)));
			run_streams(65);
		end

		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("lz77_token_packer regression: pass");
		else
			$display("lz77_token_packer regression: fail");
		$finish;
	end

endmodule
